[rtl/lmbam_pkg.sv]
// ----------------------------------------------------------------------------
// lmbam_pkg
// Shared types, codes and helpers of the LED matrix BAM scan engine.
// ----------------------------------------------------------------------------
package lmbam_pkg;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_POST  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_DRAIN
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear;   // zero the next store word of the sweep
    logic write;   // store word write
    logic tick;    // emit result, advance counters
    logic post;    // frame-ready post
    logic done;    // link transfer done
    logic issue;   // issue one row-preparation read
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic issue_last;
    logic link_busy;
    logic out_full;
  } status_t;

  // Nibble bit used in a subframe: weights 1,2,2,4,4,4,4 then 8
  function automatic logic [1:0] bam_bit_sel(input logic [3:0] subframe);
    logic [1:0] sel;
    case (subframe) inside
      4'd0:             sel = 2'd0;
      4'd1, 4'd2:       sel = 2'd1;
      [4'd3:4'd6]:      sel = 2'd2;
      default:          sel = 2'd3;
    endcase
    return sel;
  endfunction

endpackage

[rtl/lmbam_in_if.sv]
// ----------------------------------------------------------------------------
// lmbam_in_if
// Request channel: store writes, refresh ticks, frame-ready posts, link done.
// ----------------------------------------------------------------------------
interface lmbam_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        bank;
  logic [8:0]  word_addr;
  logic [31:0] word_data;

  modport source (output valid, kind, bank, word_addr, word_data, input ready);
  modport sink   (input valid, kind, bank, word_addr, word_data, output ready);
endinterface

[rtl/lmbam_out_if.sv]
// ----------------------------------------------------------------------------
// lmbam_out_if
// Result channel: row address, six lane words, vsync and shown bank.
// ----------------------------------------------------------------------------
interface lmbam_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_addr;
  logic [31:0] lane_word_0;
  logic [31:0] lane_word_1;
  logic [31:0] lane_word_2;
  logic [31:0] lane_word_3;
  logic [31:0] lane_word_4;
  logic [31:0] lane_word_5;
  logic        vsync;
  logic        shown_bank;

  modport source (output valid, row_addr, lane_word_0, lane_word_1, lane_word_2,
                  lane_word_3, lane_word_4, lane_word_5, vsync, shown_bank,
                  input ready);
  modport sink   (input valid, row_addr, lane_word_0, lane_word_1, lane_word_2,
                  lane_word_3, lane_word_4, lane_word_5, vsync, shown_bank,
                  output ready);
endinterface

[rtl/lmbam_ctrl.sv]
// ----------------------------------------------------------------------------
// lmbam_ctrl
// Sequencer: clear sweep, request decode, row preparation read loop.
// ----------------------------------------------------------------------------
module lmbam_ctrl
  import lmbam_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  output logic       in_ready,
  input  logic       out_ready,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   accept;
  kind_t  kind;

  assign kind   = kind_t'(in_kind);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && kind == KIND_TICK && !status.link_busy) state_next = ST_PREP;
      end
      ST_PREP: begin
        if (status.issue_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        // result slot must be free or draining this cycle
        in_ready  = !status.out_full || out_ready;
        cmd.write = accept && kind == KIND_WRITE;
        cmd.tick  = accept && kind == KIND_TICK && !status.link_busy;
        cmd.post  = accept && kind == KIND_POST;
        cmd.done  = accept && kind == KIND_DONE;
      end
      ST_PREP: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/lmbam_dp.sv]
// ----------------------------------------------------------------------------
// lmbam_dp
// Datapath: frame store, scan counters, lane word gather, result register.
// ----------------------------------------------------------------------------
module lmbam_dp
  import lmbam_pkg::*;
#(
  parameter int ROW_PAIRS     = 16,
  parameter int SUBFRAMES     = 15,
  parameter int WORDS_PER_ROW = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        in_bank,
  input  logic [8:0]  in_word_addr,
  input  logic [31:0] in_word_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_row_addr,
  output logic [31:0] out_lane_word [6],
  output logic        out_vsync,
  output logic        out_shown_bank
);

  localparam int BANK_WORDS = 2 * ROW_PAIRS * WORDS_PER_ROW;
  localparam int MEM_DEPTH  = 2 * BANK_WORDS;
  localparam int AW         = $clog2(MEM_DEPTH);
  localparam int RW         = $clog2(ROW_PAIRS);

  // frame store: two banks, bottom half rows follow top half rows
  logic [31:0]   mem [MEM_DEPTH];
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          we;
  logic [AW-1:0] clr_addr;

  // scan state
  logic          back_select;
  logic [RW-1:0] row_count;
  logic [3:0]    subframe_count;
  logic          link_busy;
  logic          swap_pending;
  logic [31:0]   prepared [6];

  // read issue counters
  logic          half;     // 0 = bottom half lanes 0..2, 1 = top half lanes 3..5
  logic [1:0]    grp;
  logic [1:0]    byt;
  logic [3:0]    pos;
  logic          pos_ok;

  // read capture stage
  logic          rd_vld;
  logic          rd_zero;
  logic [2:0]    rd_lane;
  logic [1:0]    rd_byte;
  logic [7:0]    gathered;
  logic [1:0]    bit_sel;

  // tick arithmetic
  logic          row_last;
  logic          sf_last;
  logic          wrap;
  logic          back_next;
  logic [4:0]    row_ext;

  // --- store write port -----------------------------------------------------
  always_comb begin
    if (cmd.clear) begin
      waddr = clr_addr;
      wdata = '0;
      we    = 1'b1;
    end else begin
      waddr = (in_bank ? AW'(BANK_WORDS) : AW'(0)) + AW'(in_word_addr);
      wdata = in_word_data;
      we    = cmd.write && (32'(in_word_addr) < BANK_WORDS);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !status.clear_done) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // --- read address of the current slot -------------------------------------
  assign pos    = {grp, byt};
  assign pos_ok = 32'(pos) < WORDS_PER_ROW;

  always_comb begin
    logic [AW-1:0] row_idx;
    row_idx = AW'(row_count) + (half ? AW'(0) : AW'(ROW_PAIRS));
    raddr   = (back_select ? AW'(0) : AW'(BANK_WORDS))
            + row_idx * AW'(WORDS_PER_ROW)
            + (pos_ok ? AW'(pos) : AW'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half <= 1'b0;
      grp  <= '0;
      byt  <= '0;
    end else if (cmd.tick) begin
      half <= 1'b0;
      grp  <= '0;
      byt  <= '0;
    end else if (cmd.issue) begin
      byt <= byt + 2'd1;
      if (byt == 2'd3) begin
        if (grp == 2'd2) begin
          grp  <= '0;
          half <= 1'b1;
        end else begin
          grp <= grp + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_zero <= !pos_ok;
    rd_lane <= half ? 3'd3 + 3'(grp) : 3'(grp);
    rd_byte <= byt;
  end

  // --- gather: one bit per nibble, lowest nibble most significant -----------
  assign bit_sel = bam_bit_sel(subframe_count);

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      gathered[7-j] = !rd_zero && rdata[4*j + int'(bit_sel)];
    end
  end

  // byte swap places the first store word in the low byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) prepared[k] <= '0;
    end else if (rd_vld) begin
      for (int k = 0; k < 6; k++) begin
        if (rd_lane == 3'(k)) prepared[k][8*rd_byte +: 8] <= gathered;
      end
    end
  end

  // --- scan counters ----------------------------------------------------------
  assign row_last  = row_count == RW'(ROW_PAIRS - 1);
  assign sf_last   = subframe_count == 4'(SUBFRAMES - 1);
  assign wrap      = row_last && sf_last;
  assign back_next = back_select ^ (wrap && swap_pending);
  assign row_ext   = 5'(row_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      back_select    <= 1'b0;
      row_count      <= '0;
      subframe_count <= '0;
      link_busy      <= 1'b0;
      swap_pending   <= 1'b0;
    end else begin
      if (cmd.post) swap_pending <= 1'b1;
      if (cmd.done) link_busy <= 1'b0;
      if (cmd.tick) begin
        link_busy <= 1'b1;
        row_count <= row_last ? '0 : row_count + RW'(1);
        if (row_last) subframe_count <= sf_last ? 4'd0 : subframe_count + 4'd1;
        if (wrap) begin
          back_select  <= back_next;
          swap_pending <= 1'b0;
        end
      end
    end
  end

  // --- result register --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      out_row_addr   <= row_ext[3:0];
      out_lane_word  <= prepared;
      out_vsync      <= wrap;
      out_shown_bank <= ~back_next;
    end
  end

  assign status.clear_done = clr_addr == AW'(MEM_DEPTH - 1);
  assign status.issue_last = half && grp == 2'd2 && byt == 2'd3;
  assign status.link_busy  = link_busy;
  assign status.out_full   = out_valid;

endmodule

[rtl/led_matrix_bam_scan_engine.sv]
// ----------------------------------------------------------------------------
// led_matrix_bam_scan_engine
// Row scan engine with bit-angle modulation and a double-buffered frame store.
// ----------------------------------------------------------------------------
// Channels (valid/ready, a request moves when both are high at a clock edge):
//   item   - requests: store word write, refresh tick, frame-ready post,
//            link transfer done.
//   result - one per refresh tick that finds the link idle: row address,
//            six lane words prepared for that row, vsync, shown bank.
// Timing: writes, posts and link-done requests leave the channel open. A tick
//   that emits loads the result register at once (result valid the next
//   cycle), then the block prepares the next row's lane words: 24 reads of
//   the single read port of the frame store, one per cycle, plus a capture
//   of the last read. A tick thus holds the item channel until the row is
//   prepared; a tick that finds the link busy is taken and dropped.
// Reset: synchronous. Counters, bank select and prepared words go to zero,
//   then a clearing pass zeroes the frame store, one word per cycle, all
//   2 * 2 * ROW_PAIRS * WORDS_PER_ROW words (768 at the defaults), with
//   item.ready low.
// Stall: the result register holds while result.ready is low; the item
//   channel is open only when idle, and is held off there while a result
//   is still waiting and not taken this cycle.
// ----------------------------------------------------------------------------
module led_matrix_bam_scan_engine
  import lmbam_pkg::*;
#(
  parameter int ROW_PAIRS     = 16,
  parameter int SUBFRAMES     = 15,
  parameter int WORDS_PER_ROW = 12
) (
  input  logic clk,
  input  logic rst,
  lmbam_in_if.sink    item,
  lmbam_out_if.source result
);

  cmd_t        cmd;
  status_t     status;
  logic [31:0] lane_word [6];

  // Sequencer: decodes requests and walks the row preparation reads
  lmbam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_kind   (item.kind),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Frame store, counters, lane gather and result register
  lmbam_dp #(
    .ROW_PAIRS     (ROW_PAIRS),
    .SUBFRAMES     (SUBFRAMES),
    .WORDS_PER_ROW (WORDS_PER_ROW)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_bank        (item.bank),
    .in_word_addr   (item.word_addr),
    .in_word_data   (item.word_data),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_row_addr   (result.row_addr),
    .out_lane_word  (lane_word),
    .out_vsync      (result.vsync),
    .out_shown_bank (result.shown_bank)
  );

  assign result.lane_word_0 = lane_word[0];
  assign result.lane_word_1 = lane_word[1];
  assign result.lane_word_2 = lane_word[2];
  assign result.lane_word_3 = lane_word[3];
  assign result.lane_word_4 = lane_word[4];
  assign result.lane_word_5 = lane_word[5];

  // A waiting result that is not taken this cycle closes the item channel
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !(result.valid && !result.ready))
    else $error("item channel open while result register is blocked");

  // An emitting tick shows a result the next cycle
  a_tick_emits: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.kind == KIND_TICK && !status.link_busy)
      |=> result.valid)
    else $error("emitting tick did not load the result register");

  // Row preparation holds the item channel after an emitting tick
  a_prep_blocks: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.kind == KIND_TICK && !status.link_busy)
      |=> !item.ready)
    else $error("item accepted during row preparation");

  // The link is busy right after any emitting tick
  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.kind == KIND_TICK && !status.link_busy)
      |=> status.link_busy)
    else $error("link not marked busy after tick");

endmodule
